// ===== rtl/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared constants and types for the framed checksum receiver.
// ----------------------------------------------------------------------------
package fcr_pkg;

  // Number of payload bytes in one frame, checksum byte included.
  localparam int unsigned FRAME_LEN = 8;
  // Width of a frame store address.
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  // Width of the fill counter, which must be able to hold FRAME_LEN itself.
  localparam int unsigned FILL_W    = $clog2(FRAME_LEN + 1);
  // Fixed field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Register reset values.
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h45;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h46;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 1'd1;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE  = 2'd0,
    MODE_TAKE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Receive phases.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_READ = 2'd1,
    PH_TAIL = 2'd2
  } phase_e;

  // Take command from the parser to the emitter.
  typedef struct packed {
    logic go;     // a frame was waiting and is to be read out
    logic empty;  // no frame was waiting: emit one not-valid result
  } take_t;

  // Frame store write port driven by the parser.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

endpackage

// ===== rtl/fcr_frame_ram.sv =====
// ----------------------------------------------------------------------------
// fcr_frame_ram
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcr_frame_ram (
  input  logic                        clk_i,
  input  fcr_pkg::wr_t                wr_i,
  input  logic                        re_i,
  input  logic [fcr_pkg::IDX_W-1:0]   raddr_i,
  output logic [fcr_pkg::BYTE_W-1:0]  rdata_o
);

  logic [fcr_pkg::BYTE_W-1:0] mem_q [fcr_pkg::FRAME_LEN];
  logic [fcr_pkg::BYTE_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port; the data register holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fcr_parser.sv =====
// ----------------------------------------------------------------------------
// fcr_parser
// Frame parser: hunts for the header, writes the payload into the frame
// store, checks the tail and checksum, and owns the waiting flag.
// ----------------------------------------------------------------------------
module fcr_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcr_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          req_i,
  input  logic [fcr_pkg::MODE_W-1:0]    mode_i,
  input  logic [fcr_pkg::BYTE_W-1:0]    rx_byte_i,
  output fcr_pkg::wr_t                  wr_o,
  output fcr_pkg::take_t                take_o
);

  fcr_pkg::phase_e             phase_q, phase_d;
  logic [fcr_pkg::FILL_W-1:0]  fill_q, fill_d;
  logic [fcr_pkg::BYTE_W-1:0]  sum_q, sum_d;
  logic                        sum_ok_q, sum_ok_d;
  logic                        wait_q, wait_d;
  logic [fcr_pkg::BYTE_W-1:0]  hdr_q, tail_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= fcr_pkg::HEADER_RESET;
      tail_q <= fcr_pkg::TAIL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcr_pkg::REG_HEADER: hdr_q  <= cfg_data_i;
        fcr_pkg::REG_TAIL:   tail_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parser state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= fcr_pkg::PH_HUNT;
      fill_q   <= '0;
      sum_q    <= '0;
      sum_ok_q <= 1'b0;
      wait_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      sum_ok_q <= sum_ok_d;
      wait_q   <= wait_d;
    end
  end

  // Next state, store writes and take commands.
  always_comb begin
    phase_d      = phase_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    sum_ok_d     = sum_ok_q;
    wait_d       = wait_q;
    wr_o.we      = 1'b0;
    wr_o.addr    = fill_q[fcr_pkg::IDX_W-1:0];
    wr_o.data    = rx_byte_i;
    take_o.go    = 1'b0;
    take_o.empty = 1'b0;

    if (req_i) begin
      case (fcr_pkg::mode_e'(mode_i))
        fcr_pkg::MODE_BYTE: begin
          // Bytes are dropped while an accepted frame waits.
          if (!wait_q) begin
            case (phase_q)
              fcr_pkg::PH_HUNT: begin
                if (rx_byte_i == hdr_q) begin
                  phase_d = fcr_pkg::PH_READ;
                  fill_d  = '0;
                  sum_d   = '0;
                end
              end
              fcr_pkg::PH_READ: begin
                wr_o.we = 1'b1;
                fill_d  = fill_q + 1'b1;
                if (fill_q == fcr_pkg::FILL_W'(fcr_pkg::FRAME_LEN - 1)) begin
                  // Checksum byte: compare it with the sum of the others.
                  sum_ok_d = (rx_byte_i == sum_q);
                  phase_d  = fcr_pkg::PH_TAIL;
                end else begin
                  sum_d = sum_q + rx_byte_i;
                end
              end
              fcr_pkg::PH_TAIL: begin
                // The accept test takes priority over a restarting header.
                if (rx_byte_i == tail_q && sum_ok_q) begin
                  wait_d  = 1'b1;
                  phase_d = fcr_pkg::PH_HUNT;
                end else if (rx_byte_i == hdr_q) begin
                  phase_d = fcr_pkg::PH_READ;
                  fill_d  = '0;
                  sum_d   = '0;
                end else begin
                  phase_d = fcr_pkg::PH_HUNT;
                end
              end
              default: begin
                phase_d = fcr_pkg::PH_HUNT;
                fill_d  = '0;
                sum_d   = '0;
              end
            endcase
          end
        end
        fcr_pkg::MODE_TAKE: begin
          if (wait_q) begin
            take_o.go = 1'b1;
            wait_d    = 1'b0;
          end else begin
            take_o.empty = 1'b1;
          end
        end
        fcr_pkg::MODE_CLEAR: begin
          wait_d  = 1'b0;
          phase_d = fcr_pkg::PH_HUNT;
          fill_d  = '0;
          sum_d   = '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fcr_emitter.sv =====
// ----------------------------------------------------------------------------
// fcr_emitter
// Read-out sequencer: streams a stored frame through the frame store read
// port into an output register, one byte per cycle under backpressure.
// ----------------------------------------------------------------------------
module fcr_emitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fcr_pkg::take_t               take_i,
  output logic                         busy_o,
  output logic                         re_o,
  output logic [fcr_pkg::IDX_W-1:0]    raddr_o,
  input  logic [fcr_pkg::BYTE_W-1:0]   rdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         frame_valid_o,
  output logic [fcr_pkg::BYTE_W-1:0]   payload_byte_o,
  output logic [fcr_pkg::POS_W-1:0]    byte_position_o,
  output logic                         last_o
);

  logic                       iss_act_q;
  logic [fcr_pkg::IDX_W-1:0]  iss_idx_q;
  logic                       iss_end;
  // Stage that tracks the contents of the store's read data register.
  logic                       rd_vld_q;
  logic                       rd_fv_q;
  logic [fcr_pkg::IDX_W-1:0]  rd_pos_q;
  logic                       rd_last_q;
  // Output register.
  logic                       out_vld_q;
  logic                       out_fv_q;
  logic [fcr_pkg::BYTE_W-1:0] out_byte_q;
  logic [fcr_pkg::POS_W-1:0]  out_pos_q;
  logic                       out_last_q;
  logic                       out_free;
  logic                       move;

  assign out_free = !out_vld_q || out_ready_i;
  assign move     = rd_vld_q && out_free;
  assign re_o     = iss_act_q && (!rd_vld_q || move);
  assign raddr_o  = iss_idx_q;
  assign iss_end  = (iss_idx_q == fcr_pkg::IDX_W'(fcr_pkg::FRAME_LEN - 1));
  // The read stage counts as free in the cycle that its entry moves on.
  assign busy_o   = iss_act_q || (rd_vld_q && !move);

  // Read issue counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q <= 1'b0;
      iss_idx_q <= '0;
    end else if (take_i.go) begin
      iss_act_q <= 1'b1;
      iss_idx_q <= '0;
    end else if (re_o) begin
      iss_idx_q <= iss_idx_q + 1'b1;
      if (iss_end) begin
        iss_act_q <= 1'b0;
      end
    end
  end

  // Read data stage: a read, or the not-valid result of an empty take.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (re_o || take_i.empty) begin
      rd_vld_q <= 1'b1;
    end else if (move) begin
      rd_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i.empty) begin
      rd_fv_q   <= 1'b0;
      rd_pos_q  <= '0;
      rd_last_q <= 1'b1;
    end else if (re_o) begin
      rd_fv_q   <= 1'b1;
      rd_pos_q  <= iss_idx_q;
      rd_last_q <= iss_end;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_fv_q   <= rd_fv_q;
      out_byte_q <= rd_fv_q ? rdata_i : '0;
      out_pos_q  <= fcr_pkg::POS_W'(rd_pos_q);
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign frame_valid_o   = out_fv_q;
  assign payload_byte_o  = out_byte_q;
  assign byte_position_o = out_pos_q;
  assign last_o          = out_last_q;

endmodule

// ===== rtl/framed_checksum_receiver.sv =====
// ----------------------------------------------------------------------------
// framed_checksum_receiver
// Header/tail framed byte receiver with an 8-bit sum checksum and a frame
// store that is read out on request.
// ----------------------------------------------------------------------------
// Byte, clear and unused-mode requests are taken one per cycle while no
// frame read-out is in flight, and give no result. A take with a frame
// gives its results one per cycle while the output does not stall, paced by
// the frame store read port; the next request is taken as the last read
// leaves the read stage. A take without a frame gives one not-valid result,
// and such takes can follow one per cycle while the output does not stall.
// Reset clears the parser, waiting flag and handshake state at once; the
// frame store is not cleared and is only read after a complete frame.
// ----------------------------------------------------------------------------
module framed_checksum_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcr_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fcr_pkg::MODE_W-1:0]    mode_i,
  input  logic [fcr_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          frame_valid_o,
  output logic [fcr_pkg::BYTE_W-1:0]    payload_byte_o,
  output logic [fcr_pkg::POS_W-1:0]     byte_position_o,
  output logic                          last_o
);

  fcr_pkg::wr_t               wr;
  fcr_pkg::take_t             take;
  logic                       busy;
  logic                       req;
  logic                       re;
  logic [fcr_pkg::IDX_W-1:0]  raddr;
  logic [fcr_pkg::BYTE_W-1:0] rdata;

  // Requests are held off while a frame read-out is in flight.
  assign in_ready_o = !busy;
  assign req        = in_valid_i && in_ready_o;

  // Parser.
  fcr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req),
    .mode_i     (mode_i),
    .rx_byte_i  (rx_byte_i),
    .wr_o       (wr),
    .take_o     (take)
  );

  // Frame store.
  fcr_frame_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read-out sequencer.
  fcr_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .busy_o          (busy),
    .re_o            (re),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_valid_o   (frame_valid_o),
    .payload_byte_o  (payload_byte_o),
    .byte_position_o (byte_position_o),
    .last_o          (last_o)
  );

endmodule

// ===== sim/framed_checksum_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// framed_checksum_receiver_tb
// Self-checking testbench for the framed checksum receiver. A short directed
// table covers take on an empty store, extreme bytes, an ignored byte, and a
// clear in the middle of a frame. Random frames then follow under several
// header and tail settings, some with bad checksums or tails. Every result
// is compared, field by field, with a behavioural parser kept in step with
// each accepted request. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module framed_checksum_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned DRAIN_CYCLES = fcr_pkg::FRAME_LEN + 8;
  localparam int unsigned PHASE_ITEMS  = 42;
  localparam int unsigned MAX_REPORTS  = 100;

  // One result of a take request.
  typedef struct packed {
    logic                       frame_valid;
    logic [fcr_pkg::BYTE_W-1:0] payload_byte;
    logic [fcr_pkg::POS_W-1:0]  byte_position;
    logic                       last;
  } readout_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    fcr_pkg::mode_e             mode;
    logic [fcr_pkg::BYTE_W-1:0] rx_byte;
    logic                       typed;
    readout_t                   want;
  } dir_row_t;

  localparam readout_t EMPTY_TAKE = '{1'b0, 8'h00, 5'd0, 1'b1};
  localparam readout_t UNTYPED    = '0;

  // Checksum of the first directed frame: FF+00+FF+80+01+7F+45 wraps to 43.
  localparam dir_row_t DIRECTED [22] = '{
    '{fcr_pkg::MODE_TAKE,  8'h00, 1'b1, EMPTY_TAKE},
    '{fcr_pkg::MODE_NONE,  8'hFF, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h00, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h45, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'hFF, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h00, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'hFF, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h80, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h01, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h7F, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h45, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h43, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h46, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h45, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_TAKE,  8'hFF, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_TAKE,  8'h00, 1'b1, EMPTY_TAKE},
    '{fcr_pkg::MODE_BYTE,  8'h45, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h12, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_CLEAR, 8'h00, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_BYTE,  8'h46, 1'b0, UNTYPED},
    '{fcr_pkg::MODE_TAKE,  8'h00, 1'b1, EMPTY_TAKE},
    '{fcr_pkg::MODE_CLEAR, 8'hFF, 1'b0, UNTYPED}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [fcr_pkg::BYTE_W-1:0]    cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [fcr_pkg::MODE_W-1:0]    mode_i;
  logic [fcr_pkg::BYTE_W-1:0]    rx_byte_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          frame_valid_o;
  logic [fcr_pkg::BYTE_W-1:0]    payload_byte_o;
  logic [fcr_pkg::POS_W-1:0]     byte_position_o;
  logic                          last_o;

  framed_checksum_receiver u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_valid_o  (frame_valid_o),
    .payload_byte_o (payload_byte_o),
    .byte_position_o(byte_position_o),
    .last_o         (last_o)
  );

  // Shadow of the parser: registers, phase, counters and the frame store.
  logic [fcr_pkg::BYTE_W-1:0] hdr_cfg;
  logic [fcr_pkg::BYTE_W-1:0] tail_cfg;
  fcr_pkg::phase_e            rx_phase;
  logic [fcr_pkg::FILL_W-1:0] fill;
  logic [fcr_pkg::BYTE_W-1:0] run_sum;
  logic [fcr_pkg::BYTE_W-1:0] shadow_store [fcr_pkg::FRAME_LEN];
  logic                       frame_held;

  readout_t    expected_readout [$];
  int unsigned mismatch_count = 0;
  int unsigned counted_items;
  int unsigned cycle_count = 0;
  bit          in_idle_on;
  bit          out_idle_on;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Opens a fresh payload after a header byte.
  function automatic void restart_payload();
    fill    = '0;
    run_sum = '0;
    rx_phase = fcr_pkg::PH_READ;
  endfunction

  // Advances the shadow parser by one request and returns the results that
  // the request should produce, in order.
  function automatic int unsigned predict_readout(input fcr_pkg::mode_e m,
                                                  input logic [fcr_pkg::BYTE_W-1:0] b,
                                                  output readout_t res [fcr_pkg::FRAME_LEN]);
    int unsigned n;
    n = 0;
    case (m)
      fcr_pkg::MODE_BYTE: if (!frame_held) begin
        case (rx_phase)
          fcr_pkg::PH_HUNT: if (b == hdr_cfg) begin
            restart_payload();
          end
          fcr_pkg::PH_READ: begin
            if (fill < fcr_pkg::FRAME_LEN) begin
              shadow_store[fill[fcr_pkg::IDX_W-1:0]] = b;
              if (fill < fcr_pkg::FRAME_LEN - 1) run_sum = run_sum + b;
              fill = fill + 1'b1;
            end
            if (fill >= fcr_pkg::FRAME_LEN) rx_phase = fcr_pkg::PH_TAIL;
          end
          fcr_pkg::PH_TAIL: begin
            // The accept test wins over a byte that is also the header.
            if (b == tail_cfg && shadow_store[fcr_pkg::FRAME_LEN-1] == run_sum) begin
              frame_held = 1'b1;
              rx_phase   = fcr_pkg::PH_HUNT;
            end else if (b == hdr_cfg) begin
              restart_payload();
            end else begin
              rx_phase = fcr_pkg::PH_HUNT;
            end
          end
          default: begin
            rx_phase = fcr_pkg::PH_HUNT;
            fill     = '0;
            run_sum  = '0;
          end
        endcase
      end
      fcr_pkg::MODE_CLEAR: begin
        frame_held = 1'b0;
        rx_phase   = fcr_pkg::PH_HUNT;
        fill       = '0;
        run_sum    = '0;
      end
      fcr_pkg::MODE_TAKE: if (!frame_held) begin
        res[0] = EMPTY_TAKE;
        n = 1;
      end else begin
        for (int i = 0; i < fcr_pkg::FRAME_LEN; i++) begin
          res[i] = '{1'b1, shadow_store[i], fcr_pkg::POS_W'(i),
                     (i == fcr_pkg::FRAME_LEN - 1)};
        end
        n = fcr_pkg::FRAME_LEN;
        frame_held = 1'b0;
      end
      default: ;
    endcase
    return n;
  endfunction

  // Presents one request after a random gap, waits for it to be taken and
  // queues the results it should cause.
  task automatic send_request(input fcr_pkg::mode_e m, input logic [fcr_pkg::BYTE_W-1:0] b,
                              input logic typed = 1'b0, input readout_t typed_want = '0);
    int unsigned gap;
    int unsigned n;
    bit          ignored;
    readout_t    res [fcr_pkg::FRAME_LEN];
    @(negedge clk_i);
    gap = in_idle_on ? $urandom_range(0, 9) : 0;
    if ($urandom_range(0, 11) == 0) in_idle_on = !in_idle_on;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    ignored = (m == fcr_pkg::MODE_NONE) || (m == fcr_pkg::MODE_BYTE && frame_held);
    if (!ignored) counted_items++;
    n = predict_readout(m, b, res);
    if (typed) begin
      expected_readout.push_back(typed_want);
    end else begin
      for (int i = 0; i < n; i++) expected_readout.push_back(res[i]);
    end
  endtask

  // Lowers valid and waits until every result is in and the block is quiet.
  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_readout.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes both marker registers while the block is idle.
  task automatic program_markers(input logic [fcr_pkg::BYTE_W-1:0] h,
                                 input logic [fcr_pkg::BYTE_W-1:0] t);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fcr_pkg::REG_HEADER;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_idx_i  <= fcr_pkg::REG_TAIL;
    cfg_data_i <= t;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    hdr_cfg  = h;
    tail_cfg = t;
  endtask

  // Sends one frame with random content; the checksum or the tail is
  // sometimes wrong, and now and then a clear breaks the frame off.
  task automatic send_frame();
    logic [fcr_pkg::BYTE_W-1:0] data;
    logic [fcr_pkg::BYTE_W-1:0] csum;
    int unsigned                pick;
    csum = '0;
    send_request(fcr_pkg::MODE_BYTE, hdr_cfg);
    for (int k = 0; k < fcr_pkg::FRAME_LEN - 1; k++) begin
      pick = $urandom_range(0, 9);
      data = (pick == 0) ? hdr_cfg : (pick == 1) ? tail_cfg : 8'($urandom);
      csum = csum + data;
      send_request(fcr_pkg::MODE_BYTE, data);
      if ($urandom_range(0, 59) == 0) send_request(fcr_pkg::MODE_CLEAR, 8'($urandom));
    end
    if ($urandom_range(0, 4) == 0) csum = csum ^ 8'($urandom_range(1, 255));
    send_request(fcr_pkg::MODE_BYTE, csum);
    pick = $urandom_range(0, 19);
    send_request(fcr_pkg::MODE_BYTE,
                 (pick < 14) ? tail_cfg : (pick < 17) ? hdr_cfg : 8'($urandom));
  endtask

  // One random step: mostly frames followed by a take, with noise around.
  task automatic random_burst();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_frame();
      if ($urandom_range(0, 4) != 0) send_request(fcr_pkg::MODE_TAKE, 8'($urandom));
    end else if (pick < 77) begin
      send_request(fcr_pkg::MODE_TAKE, 8'($urandom));
    end else if (pick < 83) begin
      send_request(fcr_pkg::MODE_CLEAR, 8'($urandom));
    end else if (pick < 87) begin
      send_request(fcr_pkg::MODE_NONE, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) send_request(fcr_pkg::MODE_BYTE, 8'($urandom));
    end
  endtask

  // Receiver side: ready drops for a random number of cycles per result.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    out_idle_on = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = out_idle_on ? $urandom_range(0, 9) : 0;
      if ($urandom_range(0, 15) == 0) out_idle_on = !out_idle_on;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin : check_readout
    readout_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readout.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: valid %0b byte %02h pos %0d",
                                  frame_valid_o, payload_byte_o, byte_position_o));
      end else begin
        want = expected_readout.pop_front();
        if (frame_valid_o !== want.frame_valid)
          report_mismatch($sformatf("frame_valid %0b, expected %0b",
                                    frame_valid_o, want.frame_valid));
        if (payload_byte_o !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %02h, expected %02h at position %0d",
                                    payload_byte_o, want.payload_byte, want.byte_position));
        if (byte_position_o !== want.byte_position)
          report_mismatch($sformatf("byte_position %0d, expected %0d",
                                    byte_position_o, want.byte_position));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b at position %0d",
                                    last_o, want.last, want.byte_position));
      end
    end
  end

  // Reset, directed table, then random phases under several marker settings.
  initial begin : stimulus
    logic [fcr_pkg::BYTE_W-1:0] h;
    logic [fcr_pkg::BYTE_W-1:0] t;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = fcr_pkg::REG_HEADER;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    mode_i         = fcr_pkg::MODE_NONE;
    rx_byte_i      = '0;
    counted_items  = 0;
    in_idle_on     = 1'b0;
    hdr_cfg        = fcr_pkg::HEADER_RESET;
    tail_cfg       = fcr_pkg::TAIL_RESET;
    rx_phase       = fcr_pkg::PH_HUNT;
    fill           = '0;
    run_sum        = '0;
    frame_held     = 1'b0;
    for (int i = 0; i < fcr_pkg::FRAME_LEN; i++) shadow_store[i] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r]) begin
      send_request(DIRECTED[r].mode, DIRECTED[r].rx_byte, DIRECTED[r].typed, DIRECTED[r].want);
    end
    drain_requests();

    // The first phase keeps the reset markers; the rest reprogram them,
    // including the extremes and a header equal to the tail.
    for (int p = 0; p < 5; p++) begin
      case (p)
        1: begin h = 8'h00; t = 8'hFF; end
        2: begin h = 8'hFF; t = 8'h00; end
        3: begin h = 8'hA5; t = 8'hA5; end
        4: begin h = 8'($urandom); t = 8'($urandom); end
        default: begin h = hdr_cfg; t = tail_cfg; end
      endcase
      if (p != 0) program_markers(h, t);
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) random_burst();
      drain_requests();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
